@@ sv/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg
// Shared constants and types for the alias table sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 32;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // report kinds
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TABLE = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;     // write weight at entry_count, add to total
        logic clear_set;   // reset count/total/flags
        logic mark_ovf;    // set overflow flag
        logic b_init;      // start build init pass: i = 0
        logic b_init_rd;   // read scaled[i]
        logic b_init_wr;   // scale, classify, write
        logic b_pair_rd;   // read work_list[k], work_list[lp]
        logic b_pair_rd2;  // read scaled[a], scaled[b]
        logic b_pair_wr;   // alias[a]=b, scaled[b]-=..
        logic b_done;      // table ready
        logic d_mul;       // p = u * n
        logic d_rd;        // read scaled/alias at bin, f * S
        logic d_mul2;      // hold the read at bin
        logic report;      // emit a result
        logic rep_kind;
        logic [1:0] rep_status;
        logic rep_pick;    // use draw pick as index
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic table_ready;
        logic set_full;      // entry_count == MAX
        logic total_zero;
        logic overflow;
        logic init_last;     // i == n-1
        logic pair_go;       // small>0 && lp<n && n>1
        logic pair_stop;     // after step: lp>=n or k+1 reached n-1
        logic count_zero;
    } t_stat;

endpackage

@@ sv/ats_ram.sv @@
// ----------------------------------------------------------------------------
// ats_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/ats_ctrl.sv @@
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer for loads, the table build and draws.
// ----------------------------------------------------------------------------
module ats_ctrl
    import ats_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_operation,
    input  logic  i_last,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_LOAD   = 11'b000_0000_0010,
        S_IRD    = 11'b000_0000_0100,
        S_IWR    = 11'b000_0000_1000,
        S_PRD    = 11'b000_0001_0000,
        S_PRD2   = 11'b000_0010_0000,
        S_PWR    = 11'b000_0100_0000,
        S_DMUL   = 11'b000_1000_0000,
        S_DRD    = 11'b001_0000_0000,
        S_DMUL2  = 11'b010_0000_0000,
        S_DOUT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_last = i_last;
                    if (i_operation == OP_LOAD) begin
                        n_state = S_LOAD;
                    end else if (!i_stat.table_ready || i_stat.count_zero) begin
                        o_cmd.report     = 1'b1;
                        o_cmd.rep_kind   = KIND_DRAW;
                        o_cmd.rep_status = ST_NO_TABLE;
                    end else begin
                        n_state = S_DMUL;
                    end
                end
            end
            S_LOAD: begin
                // set state was already cleared if a table existed (see datapath)
                if (i_stat.set_full) begin
                    o_cmd.mark_ovf = 1'b1;
                end else begin
                    o_cmd.load_wr = 1'b1;
                end
                n_state = S_IDLE;
                if (r_last) begin
                    n_state = S_IRD;
                    o_cmd.b_init = 1'b1;
                end
            end
            S_IRD: begin
                // totals updated; decide on zero total
                if (i_stat.total_zero) begin
                    o_cmd.report     = 1'b1;
                    o_cmd.rep_kind   = KIND_BUILD;
                    o_cmd.rep_status = ST_ZERO;
                    o_cmd.clear_set  = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.b_init_rd = 1'b1;
                    n_state         = S_IWR;
                end
            end
            S_IWR: begin
                o_cmd.b_init_wr = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_IWR;
                    o_cmd.b_init_rd = 1'b1;
                end
            end
            S_PRD: begin
                if (i_stat.pair_go) begin
                    o_cmd.b_pair_rd = 1'b1;
                    n_state         = S_PRD2;
                end else begin
                    o_cmd.b_done     = 1'b1;
                    o_cmd.report     = 1'b1;
                    o_cmd.rep_kind   = KIND_BUILD;
                    o_cmd.rep_status = i_stat.overflow ? ST_DROPPED : ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_PRD2: begin
                o_cmd.b_pair_rd2 = 1'b1;
                n_state          = S_PWR;
            end
            S_PWR: begin
                o_cmd.b_pair_wr = 1'b1;
                if (i_stat.pair_stop) begin
                    o_cmd.b_done     = 1'b1;
                    o_cmd.report     = 1'b1;
                    o_cmd.rep_kind   = KIND_BUILD;
                    o_cmd.rep_status = i_stat.overflow ? ST_DROPPED : ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_DMUL: begin
                o_cmd.d_mul = 1'b1;
                n_state     = S_DRD;
            end
            S_DRD: begin
                o_cmd.d_rd = 1'b1;
                n_state    = S_DMUL2;
            end
            S_DMUL2: begin
                o_cmd.d_mul2 = 1'b1;
                n_state      = S_DOUT;
            end
            S_DOUT: begin
                o_cmd.report     = 1'b1;
                o_cmd.rep_kind   = KIND_DRAW;
                o_cmd.rep_status = ST_OK;
                o_cmd.rep_pick   = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ sv/ats_dp.sv @@
// ----------------------------------------------------------------------------
// ats_dp
// Datapath: weight store, alias store, work list, build and draw arithmetic.
// ----------------------------------------------------------------------------
module ats_dp
    import ats_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_operation,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [31:0]            i_random_fraction,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_report,
    output logic                   o_report_kind,
    output logic [7:0]             o_sample_index,
    output logic [1:0]             o_status
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = WEIGHT_BITS + AW;      // weight total
    localparam int SW = WEIGHT_BITS + CW;      // scaled weight
    localparam int FW = 32 + TW;               // f * S

    // set state
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_total;
    logic          r_ready, r_ovf;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [31:0]   r_u;

    // build indices
    logic [CW-1:0] r_i, r_small, r_lp, r_k;
    logic [AW-1:0] r_a, r_b;

    // draw pipeline
    logic [CW+31:0] r_p;
    logic [AW-1:0]  r_bin;
    logic [FW-1:0]  r_fs;

    // memory ports
    logic          sw_we, al_we, wl_we;
    logic [AW-1:0] sw_wa, sw_ra, al_wa, al_ra, wl_wa, wl_ra;
    logic [SW-1:0] sw_wd, sw_rd;
    logic [AW-1:0] al_wd, al_rd, wl_wd, wl_rd;

    // mirror copies give the large-side entry b its own read ports
    logic [AW-1:0] wl_b;
    logic [SW-1:0] sw_b_rd;

    logic [CW-1:0] n_minus1;
    logic [SW-1:0] scaled_i, sw_b_new;
    logic          init_last;
    logic [CW-1:0] bin_raw;
    logic [AW-1:0] bin_sel;
    logic          keep;

    // result register
    logic          r_rep, r_kind;
    logic [7:0]    r_idx;
    logic [1:0]    r_st;

    ats_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_sw (
        .i_clk(i_clk), .i_we(sw_we), .i_waddr(sw_wa), .i_wdata(sw_wd),
        .i_raddr(sw_ra), .o_rdata(sw_rd));
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_al (
        .i_clk(i_clk), .i_we(al_we), .i_waddr(al_wa), .i_wdata(al_wd),
        .i_raddr(al_ra), .o_rdata(al_rd));
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_wl (
        .i_clk(i_clk), .i_we(wl_we), .i_waddr(wl_wa), .i_wdata(wl_wd),
        .i_raddr(wl_ra), .o_rdata(wl_rd));
    // work list copy, read at lp: b index is valid in PRD2
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_wl2 (
        .i_clk(i_clk), .i_we(wl_we), .i_waddr(wl_wa), .i_wdata(wl_wd),
        .i_raddr(r_lp[AW-1:0]), .o_rdata(wl_b));
    // scaled weight copy, read at b: scaled[b] is valid in PWR
    ats_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_sw2 (
        .i_clk(i_clk), .i_we(sw_we), .i_waddr(sw_wa), .i_wdata(sw_wd),
        .i_raddr(wl_b), .o_rdata(sw_b_rd));

    assign n_minus1  = r_count - CW'(1);
    assign init_last = (r_i == n_minus1);
    // scaled weight read back from the store holds the raw weight during init
    assign scaled_i = SW'(sw_rd[WEIGHT_BITS-1:0]) * SW'(r_count);
    // in PWR sw_rd holds scaled[a] and sw_b_rd holds scaled[b]
    assign sw_b_new = sw_b_rd - (SW'(r_total) - sw_rd);

    // memory addressing
    always_comb begin
        sw_we = 1'b0; sw_wa = r_count[AW-1:0]; sw_wd = SW'(r_w);
        sw_ra = r_i[AW-1:0];
        al_we = 1'b0; al_wa = r_i[AW-1:0]; al_wd = r_i[AW-1:0];
        al_ra = r_bin;
        wl_we = 1'b0; wl_wa = r_small[AW-1:0]; wl_wd = r_i[AW-1:0];
        wl_ra = r_k[AW-1:0];
        if (i_cmd.load_wr) begin
            sw_we = 1'b1;
        end
        if (i_cmd.b_init_wr) begin
            sw_we = 1'b1; sw_wa = r_i[AW-1:0]; sw_wd = scaled_i;
            al_we = 1'b1;
            wl_we = 1'b1;
            if (scaled_i < SW'(r_total)) begin
                wl_wa = r_small[AW-1:0];
            end else begin
                wl_wa = AW'(r_lp - CW'(1));
            end
        end
        if (i_cmd.b_init_rd && i_cmd.b_init_wr) begin
            sw_ra = AW'(r_i + CW'(1));
        end
        if (i_cmd.b_pair_rd) begin
            wl_ra = r_k[AW-1:0];
        end
        if (i_cmd.b_pair_rd2) begin
            sw_ra = wl_rd;
        end
        if (i_cmd.d_rd) begin
            sw_ra = bin_sel;
            al_ra = bin_sel;
        end
        if (i_cmd.d_mul2) begin
            sw_ra = r_bin;
        end
        if (i_cmd.b_pair_wr) begin
            al_we = 1'b1; al_wa = r_a; al_wd = r_b;
            sw_we = 1'b1; sw_wa = r_b; sw_wd = sw_b_new;
        end
    end

    // set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_total <= '0; r_ready <= 1'b0; r_ovf <= 1'b0;
        end else begin
            // a load after a built table starts a fresh set
            if (i_start && i_operation == OP_LOAD && r_ready) begin
                r_count <= '0; r_total <= '0; r_ovf <= 1'b0; r_ready <= 1'b0;
            end
            if (i_cmd.load_wr) begin
                r_count <= r_count + CW'(1);
                r_total <= r_total + TW'(r_w);
            end
            if (i_cmd.mark_ovf) r_ovf <= 1'b1;
            if (i_cmd.clear_set) begin
                r_count <= '0; r_total <= '0; r_ovf <= 1'b0; r_ready <= 1'b0;
            end
            if (i_cmd.b_done) r_ready <= 1'b1;
        end
    end

    // build and draw registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_weight;
            r_u <= i_random_fraction;
        end
        if (i_cmd.b_init) begin
            // the last weight is counted at this same edge
            r_i <= '0; r_small <= '0; r_lp <= r_count + CW'(i_cmd.load_wr); r_k <= '0;
        end
        if (i_cmd.b_init_wr) begin
            r_i <= r_i + CW'(1);
            if (scaled_i < SW'(r_total)) r_small <= r_small + CW'(1);
            else r_lp <= r_lp - CW'(1);
        end
        if (i_cmd.b_pair_rd2) begin
            r_a <= wl_rd;
            r_b <= wl_b;
        end
        if (i_cmd.b_pair_wr) begin
            r_k <= r_k + CW'(1);
            if (sw_b_new < SW'(r_total)) r_lp <= r_lp + CW'(1);
        end
        if (i_cmd.d_mul) begin
            r_p <= (CW+32)'(r_u) * (CW+32)'(r_count);
        end
        if (i_cmd.d_rd) begin
            r_fs  <= FW'(r_p[31:0]) * FW'(r_total);
            r_bin <= bin_sel;
        end
    end

    // draw decision: f*S < sw * 2^32
    assign bin_raw = r_p[CW+31:32];
    assign bin_sel = (bin_raw >= r_count) ? n_minus1[AW-1:0] : bin_raw[AW-1:0];
    assign keep = ({r_fs, 1'b0} < {sw_rd, 32'd0, 1'b0});

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= 1'b0;
        end else begin
            r_rep <= i_cmd.report;
        end
        r_kind <= i_cmd.rep_kind;
        r_st   <= i_cmd.rep_status;
        r_idx  <= i_cmd.rep_pick ? 8'(keep ? r_bin : al_rd) : 8'd0;
    end

    assign o_report       = r_rep;
    assign o_report_kind  = r_kind;
    assign o_sample_index = r_idx;
    assign o_status       = r_st;

    always_comb begin
        o_stat            = '0;
        o_stat.table_ready = r_ready;
        o_stat.set_full   = (r_count == CW'(MAX_ENTRIES));
        o_stat.total_zero = (r_total == '0);
        o_stat.overflow   = r_ovf;
        o_stat.init_last  = init_last;
        o_stat.pair_go    = (r_small != '0) && (r_lp < r_count) && (r_count > CW'(1));
        o_stat.pair_stop  = (((sw_b_new < SW'(r_total)) ? r_lp + CW'(1) : r_lp) >= r_count)
                            || (r_k + CW'(2) >= r_count);
        o_stat.count_zero = (r_count == '0);
    end
endmodule

@@ sv/alias_table_sampler.sv @@
// ----------------------------------------------------------------------------
// alias_table_sampler
// Integer Walker alias-method sampler: load weights, build, draw.
// ----------------------------------------------------------------------------
// channel  | ports                                               | control
// input    | i_operation, i_weight, i_last, i_random_fraction    | start / busy
// result   | o_report_kind, o_sample_index, o_status             | o_report strobe
//
// A load passes through the load state; a draw through multiply, store read with
// the second multiply, read hold and compare, the compare result being registered.
// A draw before a build reports in the cycle after its transfer, busy stays low.
// The build after the last weight: a read state, the scale pass, then pair read,
// second read and write per pairing step; b is read through mirror stores.
// Reset is synchronous; stores are undefined until written.
// Results strobe for one cycle and cannot be stalled.
module alias_table_sampler
    import ats_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_last,
    input  logic [31:0]            i_random_fraction,
    output logic                   o_report,
    output logic                   o_report_kind,
    output logic [7:0]             o_sample_index,
    output logic [1:0]             o_status
);
    t_cmd  cmd;
    t_stat stat;

    ats_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_operation(i_operation), .i_last(i_last), .i_stat(stat),
        .o_busy(busy), .o_cmd(cmd));

    ats_dp #(.MAX_ENTRIES(MAX_ENTRIES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_operation(i_operation), .i_weight(i_weight),
        .i_random_fraction(i_random_fraction), .i_cmd(cmd), .o_stat(stat),
        .o_report(o_report), .o_report_kind(o_report_kind),
        .o_sample_index(o_sample_index), .o_status(o_status));
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alias table sampler: weight sets are loaded and
// built, draws are compared against a behavioral alias-table predictor.
// ----------------------------------------------------------------------------
module tb
    import ats_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = MAX_ENTRIES_DEF;

    typedef struct packed {
        logic       kind;
        logic [7:0] index;
        logic [1:0] status;
    } t_report;

    typedef struct {
        logic        op;
        logic [31:0] weight;
        logic        last;
        logic [31:0] frac;
        logic        has_exp;
        t_report     exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [31:0] i_weight;
    logic        i_last;
    logic [31:0] i_random_fraction;
    logic        o_report;
    logic        o_report_kind;
    logic [7:0]  o_sample_index;
    logic [1:0]  o_status;

    alias_table_sampler DUT (.*);

    // predictor state
    logic [40:0] pw_scaled [NMAX];
    logic [7:0]  pw_alias  [NMAX];
    int unsigned pw_list   [NMAX];
    int unsigned pw_count;
    logic [39:0] pw_total;
    bit          pw_ready;
    bit          pw_ovf;

    t_report     pending_reports[$];
    int          mismatches;
    int          idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void set_clear();
        pw_count = 0;
        pw_total = '0;
        pw_ovf   = 1'b0;
        pw_ready = 1'b0;
    endfunction

    function automatic void table_build();
        int unsigned n, n_small, lp, a, b;
        n = pw_count;
        n_small = 0;
        lp = n;
        for (int unsigned i = 0; i < n; i++) begin
            pw_alias[i]  = i[7:0];
            pw_scaled[i] = pw_scaled[i] * n;
            if (pw_scaled[i] < {1'b0, pw_total}) begin
                pw_list[n_small] = i;
                n_small++;
            end else begin
                lp--;
                pw_list[lp] = i;
            end
        end
        if (n_small > 0 && lp < n) begin
            for (int unsigned k = 0; k + 1 < n; k++) begin
                a = pw_list[k];
                b = pw_list[lp];
                pw_alias[a] = b[7:0];
                pw_scaled[b] = pw_scaled[b] - ({1'b0, pw_total} - pw_scaled[a]);
                if (pw_scaled[b] < {1'b0, pw_total})
                    lp++;
                if (lp >= n)
                    break;
            end
        end
        pw_ready = 1'b1;
    endfunction

    // advance the predictor by one accepted transfer
    function automatic void predict_sample(logic op, logic [31:0] w, logic last,
                                           logic [31:0] u);
        t_report     r;
        logic [63:0] p;
        int unsigned bin;
        logic [95:0] lhs, rhs;
        if (op == OP_LOAD) begin
            if (pw_ready)
                set_clear();
            if (pw_count < NMAX) begin
                pw_scaled[pw_count] = {9'd0, w};
                pw_total = pw_total + w;
                pw_count++;
            end else begin
                pw_ovf = 1'b1;
            end
            if (!last)
                return;
            r.kind  = KIND_BUILD;
            r.index = '0;
            if (pw_total == 0) begin
                r.status = ST_ZERO;
                set_clear();
            end else begin
                r.status = pw_ovf ? ST_DROPPED : ST_OK;
                table_build();
            end
            pending_reports.push_back(r);
            return;
        end
        r.kind = KIND_DRAW;
        if (!pw_ready || pw_count == 0) begin
            r.index  = '0;
            r.status = ST_NO_TABLE;
        end else begin
            p   = {32'd0, u} * 64'(pw_count);
            bin = p[63:32];
            if (bin >= pw_count)
                bin = pw_count - 1;
            lhs = 96'(p[31:0]) * 96'(pw_total);
            rhs = {23'd0, pw_scaled[bin], 32'd0};
            r.index  = (lhs < rhs) ? bin[7:0] : pw_alias[bin];
            r.status = ST_OK;
        end
        pending_reports.push_back(r);
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && o_report) begin
            got = '{o_report_kind, o_sample_index, o_status};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d idx=%0d st=%0d",
                             got.kind, got.index, got.status);
            end else begin
                want = pending_reports.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp kind=%0d idx=%0d st=%0d, got %0d %0d %0d",
                                 want.kind, want.index, want.status,
                                 got.kind, got.index, got.status);
                end
            end
        end
    end

    // one transfer, with optional idle cycles before it
    task automatic send_item(logic op, logic [31:0] w, logic last, logic [31:0] u);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_operation       <= op;
        i_weight          <= w;
        i_last            <= last;
        i_random_fraction <= u;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_sample(op, w, last, u);
    endtask

    // sender pauses until every expected result has come
    task automatic drain_wait();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // random weight set of the given size, then a few draws
    task automatic random_set(int unsigned n, int unsigned draws);
        for (int unsigned i = 0; i < n; i++)
            send_item(OP_LOAD, rand_weight(), i == n - 1, $urandom);
        for (int unsigned d = 0; d < draws; d++)
            send_item(OP_DRAW, $urandom, 1'($urandom_range(1)), $urandom);
    endtask

    t_row rows[$];

    function automatic void add_row(logic op, logic [31:0] w, logic last, logic [31:0] u,
                                    logic has_exp, logic [1:0] st);
        t_row r;
        r.op = op; r.weight = w; r.last = last; r.frac = u;
        r.has_exp = has_exp;
        r.exp = '{op == OP_DRAW ? KIND_DRAW : KIND_BUILD, 8'd0, st};
        rows.push_back(r);
    endfunction

    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_operation = OP_LOAD;
        i_weight = '0; i_last = 1'b0; i_random_fraction = '0;
        mismatches = 0; idle_pct = 0;
        set_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: draw before build, zero set, extremes, one-entry set
        add_row(OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_NO_TABLE);
        add_row(OP_LOAD, 32'd0, 1'b0, 32'd0, 1'b0, ST_OK);
        add_row(OP_LOAD, 32'd0, 1'b1, 32'd0, 1'b1, ST_ZERO);
        add_row(OP_DRAW, 32'd5, 1'b1, 32'd0, 1'b1, ST_NO_TABLE);
        add_row(OP_LOAD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK);
        add_row(OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK);
        add_row(OP_LOAD, 32'd1, 1'b0, 32'd0, 1'b0, ST_OK);
        add_row(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, ST_OK);
        add_row(OP_LOAD, 32'd0, 1'b0, 32'd0, 1'b0, ST_OK);
        add_row(OP_LOAD, 32'd7, 1'b1, 32'd0, 1'b1, ST_OK);
        add_row(OP_DRAW, 32'd0, 1'b0, 32'd0, 1'b0, ST_OK);
        add_row(OP_DRAW, 32'd0, 1'b0, 32'h8000_0000, 1'b0, ST_OK);
        add_row(OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK);
        add_row(OP_DRAW, 32'd0, 1'b0, 32'h5555_5555, 1'b0, ST_OK);
        foreach (rows[i]) begin
            send_item(rows[i].op, rows[i].weight, rows[i].last, rows[i].frac);
            if (rows[i].has_exp)
                pending_reports[pending_reports.size() - 1] = rows[i].exp;
        end
        drain_wait();

        // capacity overflow: one full set plus a dropped weight
        for (int i = 0; i < NMAX + 1; i++)
            send_item(OP_LOAD, $urandom, i == NMAX, 32'd0);
        for (int d = 0; d < 12; d++)
            send_item(OP_DRAW, $urandom, 1'b0, $urandom);
        drain_wait();

        // random part, in idle phases
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 78 : (ph == 3) ? 23 : 0;
            for (int s = 0; s < 3; s++) begin
                random_set($urandom_range(1, 6), $urandom_range(3, 9));
                if ($urandom_range(3) == 0)
                    send_item(OP_LOAD, rand_weight(), 1'b0, $urandom);
            end
            if (ph == 2)
                random_set($urandom_range(10, 16), 6);
            drain_wait();
        end

        drain_wait();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ats_pkg.sv
sv/ats_ram.sv
sv/ats_ctrl.sv
sv/ats_dp.sv
sv/alias_table_sampler.sv
verif/tb.sv
